### rtl/fba_pkg.sv
`default_nettype none

package fba_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned BBYTES_W  = 13;
  localparam int unsigned BCOUNT_W  = 7;
  localparam int unsigned STRIDE_W  = 14;
  localparam int unsigned BNUM_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = ADDR_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_MISALIGN = 3'd3,
    ST_NOTUSED  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RANGE,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                start;
    logic [ADDR_W-1:0]   dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ADDR_W-1:0]   quot;
    logic [STRIDE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/fba_if.sv
`default_nettype none

interface fba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [fba_pkg::ADDR_W-1:0] release_address;

  modport source (output valid, mode, release_address, input ready);
  modport sink (input valid, mode, release_address, output ready);
endinterface

interface fba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [fba_pkg::ADDR_W-1:0] granted_address;
  logic [fba_pkg::BNUM_W-1:0] block_number;

  modport source (output valid, status, granted_address, block_number, input ready);
  modport sink (input valid, status, granted_address, block_number, output ready);
endinterface

interface fba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::CFG_IDX_W-1:0] index;
  logic [fba_pkg::ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/fba_ram.sv
`default_nettype none

module fba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/fba_div.sv
`default_nettype none

module fba_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fba_pkg::div_req_t req_i,
  output fba_pkg::div_rsp_t      rsp_o
);

  import fba_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [STRIDE_W-1:0] rem_q;
  logic [ADDR_W-1:0]   quo_q;
  logic [STRIDE_W-1:0] dvs_q;
  logic [STRIDE_W:0]   rem_sh;
  logic [STRIDE_W:0]   diff;
  logic                ge;
  logic                last;

  // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
  assign rem_sh = {rem_q, quo_q[ADDR_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign last   = (cnt_q == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[STRIDE_W-1:0] : rem_sh[STRIDE_W-1:0];
      quo_q <= {quo_q[ADDR_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

### rtl/fixed_block_allocator_unit.sv
// Allocate: blocks are probed in turn, a map read then a check, until one is free or all are.
// Free: the offset is divided by the stride in the 32-step serial divider unless out of range.
// One request is in flight at a time; the unit returns to idle, ready for the next request, as
// its result enters the output register, once any earlier result there has been accepted.
// After reset all MAX_BLOCKS entries of the used-block map are cleared with request ready low.
// Configuration writes are taken on any cycle.
`default_nettype none

module fixed_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS  = 64,
  parameter int unsigned GUARD_BYTES = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fba_req_if.sink     req_i,
  fba_rsp_if.source   rsp_o,
  fba_cfg_if.sink     cfg_i
);

  import fba_pkg::*;

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMP_W = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
  localparam int unsigned PS_W  = STRIDE_W + CMP_W;
  localparam int unsigned RW    = (PS_W > ADDR_W) ? PS_W : ADDR_W;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]   base_q;
  logic [BBYTES_W-1:0] bbytes_q;
  logic [BCOUNT_W-1:0] bcount_q;

  logic [ADDR_W-1:0]   addr_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]   off_q, off_d;
  logic [PS_W-1:0]     psize_q;

  status_e             res_status_q, res_status_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic [BNUM_W-1:0]   res_num_q, res_num_d;

  logic                rsp_valid_q, rsp_valid_d;
  status_e             rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]   rsp_addr_q, rsp_addr_d;
  logic [BNUM_W-1:0]   rsp_num_q, rsp_num_d;

  logic [CMP_W-1:0]    eff_cnt;
  logic [CMP_W-1:0]    bcount_w;
  logic [STRIDE_W-1:0] stride;
  logic [ADDR_W-1:0]   offset;
  logic                out_of_range;
  logic                last_probe;
  logic                req_xfer;
  logic                out_free;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic                ram_wdata;
  logic                ram_rdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign bcount_w     = CMP_W'(bcount_q);
  assign eff_cnt      = (bcount_w > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : bcount_w;
  assign stride       = STRIDE_W'(bbytes_q) + STRIDE_W'(GUARD_BYTES);
  assign offset       = addr_q - base_q;
  assign out_of_range = (addr_q < base_q) || (RW'(offset) >= RW'(psize_q));
  assign last_probe   = ((CMP_W'(idx_q) + CMP_W'(1)) >= eff_cnt);
  assign req_xfer     = req_i.valid && req_i.ready;
  assign out_free     = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.granted_address = rsp_addr_q;
  assign rsp_o.block_number    = rsp_num_q;

  fba_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  fba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (idx_q == IDX_W'(MAX_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_xfer) begin
          if (req_i.mode) begin
            state_d = S_FREE_RANGE;
          end else if (eff_cnt == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ALLOC_RD;
          end
        end
      end
      S_ALLOC_RD: begin
        state_d = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (!ram_rdata || last_probe) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ALLOC_RD;
        end
      end
      S_FREE_RANGE: begin
        state_d = out_of_range ? S_DONE : S_FREE_DIV;
      end
      S_FREE_DIV: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.rem != '0) ? S_DONE : S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_d            = idx_q;
    off_d            = off_q;
    res_status_d     = res_status_q;
    res_addr_d       = res_addr_q;
    res_num_d        = res_num_q;
    ram_we           = 1'b0;
    ram_waddr        = idx_q;
    ram_wdata        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = offset;
    div_req.divisor  = stride;
    rsp_valid_d      = rsp_valid_q && !rsp_o.ready;
    rsp_status_d     = rsp_status_q;
    rsp_addr_d       = rsp_addr_q;
    rsp_num_d        = rsp_num_q;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_q == IDX_W'(MAX_BLOCKS - 1)) begin
          idx_d = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        idx_d        = '0;
        off_d        = '0;
        res_status_d = ST_FULL;
        res_addr_d   = '0;
        res_num_d    = '0;
      end
      S_ALLOC_CHK: begin
        if (!ram_rdata) begin
          ram_we       = 1'b1;
          ram_wdata    = 1'b1;
          res_status_d = ST_OK;
          res_addr_d   = base_q + off_q;
          res_num_d    = BNUM_W'(idx_q);
        end else if (last_probe) begin
          res_status_d = ST_FULL;
          res_addr_d   = '0;
          res_num_d    = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
          off_d = off_q + ADDR_W'(stride);
        end
      end
      S_FREE_RANGE: begin
        res_addr_d = '0;
        res_num_d  = '0;
        if (out_of_range) begin
          res_status_d = ST_RANGE;
        end else begin
          div_req.start = 1'b1;
        end
      end
      S_FREE_DIV: begin
        if (div_rsp.done) begin
          res_status_d = ST_MISALIGN;
          idx_d        = div_rsp.quot[IDX_W-1:0];
        end
      end
      S_FREE_CHK: begin
        if (!ram_rdata) begin
          res_status_d = ST_NOTUSED;
        end else begin
          ram_we       = 1'b1;
          ram_wdata    = 1'b0;
          res_status_d = ST_OK;
          res_num_d    = BNUM_W'(idx_q);
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_addr_d   = res_addr_q;
          rsp_num_d    = res_num_q;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
      base_q      <= '0;
      bbytes_q    <= BBYTES_W'(16);
      bcount_q    <= BCOUNT_W'(64);
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_POOL_BASE:     base_q   <= cfg_i.data;
          CFG_BLOCK_BYTES:   bbytes_q <= cfg_i.data[BBYTES_W-1:0];
          CFG_BLOCKS_IN_USE: bcount_q <= cfg_i.data[BCOUNT_W-1:0];
          default: begin
            base_q <= base_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      addr_q <= req_i.release_address;
    end
    off_q        <= off_d;
    psize_q      <= PS_W'(stride) * PS_W'(eff_cnt);
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_num_q    <= res_num_d;
    rsp_status_q <= rsp_status_d;
    rsp_addr_q   <= rsp_addr_d;
    rsp_num_q    <= rsp_num_d;
  end

endmodule

`default_nettype wire

### rtl/fba_chk.sv
`default_nettype none

module fba_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         req_valid_i,
  input wire logic                         req_ready_i,
  input wire logic                         rsp_valid_i,
  input wire logic                         rsp_ready_i,
  input wire logic [2:0]                   rsp_status_i,
  input wire logic [fba_pkg::ADDR_W-1:0]   rsp_addr_i,
  input wire logic [fba_pkg::BNUM_W-1:0]   rsp_num_i
);

  import fba_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_addr_i) && $stable(rsp_num_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_addr_i == '0) && (rsp_num_i == '0))
    else $error("error result carries a nonzero address or block number");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still in work");

  a_addr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_addr_i != '0) |-> (rsp_status_i == ST_OK))
    else $error("granted address without a successful allocation");

endmodule

bind fixed_block_allocator_unit fba_chk u_fba_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_addr_i   (rsp_o.granted_address),
  .rsp_num_i    (rsp_o.block_number)
);

`default_nettype wire
